FILE: hdl/sorted_range_table_lookup_unit_assert.svh
// assertion macros for the sorted range table lookup unit
// included by the port checker, expects clk_i and rst_ni in scope
`ifndef SORTED_RANGE_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define SORTED_RANGE_TABLE_LOOKUP_UNIT_ASSERT_SVH

// property checked outside reset
`define SRTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property that also has to hold while reset is applied
`define SRTL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/srtl_pkg.sv
// shared types and constants for the sorted range table lookup unit
// no dependencies; imported by every module of the block but srtl_ram
package srtl_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned LEN_W = 64;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned OP_W = 2;
  localparam int unsigned ST_W = 2;

  localparam int unsigned IN_DATA_W = 144;
  localparam int unsigned OUT_DATA_W = 88;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FIN,
    S_DONE
  } state_e;

  // one table entry as held in the ram, start in the low bits
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic clear;
    logic zero_res;
    logic miss;
    logic search_init;
    logic search_step;
    logic search_fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic in_valid;
    logic cnt_zero;
    logic hit;
    logic cont;
    logic has_right;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/srtl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module srtl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/srtl_ctrl.sv
// control state machine of the sorted range table lookup unit
// depends on srtl_pkg; drives the datapath through cmd_t, reads sts_t
module srtl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srtl_pkg::sts_t sts_i,
  output srtl_pkg::cmd_t cmd_o,
  output logic           s_ready_o
);
  import srtl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (sts_i.in_valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.op == OP_LOOKUP && !sts_i.cnt_zero) state_d = S_SEARCH;
        else state_d = S_DONE;
      end
      S_SEARCH: begin
        priority if (sts_i.hit) state_d = S_DONE;
        else if (sts_i.cont) state_d = S_SEARCH;
        else if (sts_i.has_right) state_d = S_FIN;
        else state_d = S_DONE;
      end
      S_FIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.capture = sts_i.in_valid;
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_APPEND: cmd_o.append = 1'b1;
          OP_CLEAR:  cmd_o.clear = 1'b1;
          OP_LOOKUP: begin
            if (sts_i.cnt_zero) cmd_o.miss = 1'b1;
            else cmd_o.search_init = 1'b1;
          end
          default:   cmd_o.zero_res = 1'b1;
        endcase
      end
      S_SEARCH: cmd_o.search_step = 1'b1;
      S_FIN:    cmd_o.search_fin = 1'b1;
      S_DONE:   cmd_o.load_out = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/srtl_dp.sv
// datapath: request registers, entry count, search bounds, table ram and result register
// depends on srtl_pkg and srtl_ram; steered by srtl_ctrl through cmd_t
module srtl_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srtl_pkg::cmd_t                  cmd_i,
  output srtl_pkg::sts_t                  sts_o,
  input  logic                            s_valid_i,
  input  logic [srtl_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic [srtl_pkg::OP_W-1:0]       s_user_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [srtl_pkg::OUT_DATA_W-1:0] m_data_o,
  output logic [srtl_pkg::ST_W-1:0]       m_user_o
);
  import srtl_pkg::*;

  function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                              input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - {{CNT_W{1'b0}}, 1'b1};
    return sum[IDX_W:1];
  endfunction

  // request
  op_e               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  len_q;
  logic [TAG_W-1:0]  tag_q;

  // table state
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] last_start_q;

  // search bounds, hi is one past the right end
  logic [CNT_W-1:0]  lo_q, hi_q, lo_n, hi_n, hi_m1;
  logic [IDX_W-1:0]  mid_q, rd_addr;

  // result waiting for the output register
  logic              res_found_q;
  logic [TAG_W-1:0]  res_tag_q;
  logic [ADDR_W-1:0] res_off_q;
  status_e           res_status_q;

  // output register
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [ST_W-1:0]       m_user_q;

  entry_t            wr_entry, rd_entry;
  logic              gt, hit, cont, has_right, app_ok;
  logic [ADDR_W-1:0] diff;
  status_e           app_status;

  srtl_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.append && app_ok),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(wr_entry),
    .raddr_i(rd_addr),
    .rdata_o(rd_entry)
  );

  assign wr_entry.start  = addr_q;
  assign wr_entry.length = len_q;
  assign wr_entry.tag    = tag_q;

  always_comb begin
    priority if (addr_q == '0) app_status = ST_ZERO;
    else if (count_q == CNT_W'(TABLE_DEPTH)) app_status = ST_FULL;
    else if (count_q != '0 && addr_q < last_start_q) app_status = ST_ORDER;
    else app_status = ST_OK;
  end
  assign app_ok = (app_status == ST_OK);

  // probe evaluation on the entry read at mid_q
  assign gt   = rd_entry.start > addr_q;
  assign diff = addr_q - rd_entry.start;
  assign hit  = !gt && (diff < rd_entry.length);

  assign lo_n      = gt ? lo_q : CNT_W'(mid_q) + CNT_W'(1);
  assign hi_n      = gt ? CNT_W'(mid_q) : hi_q;
  assign cont      = lo_n < hi_n;
  assign has_right = hi_n != '0;
  assign hi_m1     = hi_n - CNT_W'(1);

  always_comb begin
    priority if (cmd_i.search_init) rd_addr = mid_of('0, count_q);
    else if (cont) rd_addr = mid_of(lo_n, hi_n);
    else rd_addr = hi_m1[IDX_W-1:0];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) count_d = '0;
    else if (cmd_i.append && app_ok) count_d = count_q + CNT_W'(1);
  end

  assign m_valid_d = cmd_i.load_out || (m_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(s_user_i);
      addr_q <= s_data_i[ADDR_W-1:0];
      len_q  <= s_data_i[ADDR_W+LEN_W-1:ADDR_W];
      tag_q  <= s_data_i[ADDR_W+LEN_W+TAG_W-1:ADDR_W+LEN_W];
    end
    if (cmd_i.append && app_ok) begin
      last_start_q <= addr_q;
    end
    if (cmd_i.search_init) begin
      lo_q  <= '0;
      hi_q  <= count_q;
      mid_q <= rd_addr;
    end
    if (cmd_i.search_step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= rd_addr;
    end

    priority if (cmd_i.append) begin
      res_found_q  <= 1'b0;
      res_tag_q    <= '0;
      res_off_q    <= '0;
      res_status_q <= app_status;
    end else if (cmd_i.clear || cmd_i.zero_res) begin
      res_found_q  <= 1'b0;
      res_tag_q    <= '0;
      res_off_q    <= '0;
      res_status_q <= ST_OK;
    end else if (cmd_i.miss || (cmd_i.search_step && !hit && !cont && !has_right)) begin
      res_found_q  <= 1'b0;
      res_tag_q    <= '0;
      res_off_q    <= addr_q;
      res_status_q <= ST_OK;
    end else if (cmd_i.search_fin || (cmd_i.search_step && hit)) begin
      res_found_q  <= 1'b1;
      res_tag_q    <= rd_entry.tag;
      res_off_q    <= diff;
      res_status_q <= ST_OK;
    end else begin
      res_found_q  <= res_found_q;
    end

    if (cmd_i.load_out) begin
      m_data_q <= {{(OUT_DATA_W - ADDR_W - TAG_W - 1){1'b0}}, res_off_q, res_tag_q,
                   res_found_q};
      m_user_q <= res_status_q;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.in_valid  = s_valid_i;
  assign sts_o.cnt_zero  = count_q == '0;
  assign sts_o.hit       = hit;
  assign sts_o.cont      = cont;
  assign sts_o.has_right = has_right;
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

endmodule

FILE: hdl/sorted_range_table_lookup_unit.sv
// sorted range table lookup unit: table of address ranges with binary search
//
// requests come in on the s_axis channel, tuser carrying the operation
// (append, look up, clear) and tdata the address, length and tag. every
// request gives exactly one result on the m_axis channel: found, hit_tag
// and offset in tdata, status in tuser.
// one request is worked on at a time. append, clear and the unused
// operation go from acceptance through the execute and done states to a
// valid result. a lookup goes through execute, one search pass per probe
// (at most ceil(log2(n+1)) probes for n stored entries, 13 for a full
// table), a final state when the search ends without a containing entry
// and falls back to the entry on the right bound, and then done; the
// probe loop is set by the registered read of the table ram, one probe per
// cycle. a new request is taken after the result enters the output register.
// reset empties the table (entry count zero, no ram clearing pass) and drops
// any pending result. when the receiver stalls, the result is held in the
// output register; the next request is computed but waits for that register
// to free before it is handed on.
// depends on srtl_pkg, srtl_ctrl, srtl_dp and srtl_ram
module sorted_range_table_lookup_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [srtl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // addr, length, tag
  input  logic [srtl_pkg::OP_W-1:0]       s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [srtl_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // found, hit_tag, offset, zero pad
  output logic [srtl_pkg::ST_W-1:0]       m_axis_tuser   // status
);
  import srtl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srtl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .s_ready_o(s_axis_tready)
  );

  srtl_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .s_valid_i(s_axis_tvalid),
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_user_o (m_axis_tuser)
  );

endmodule

FILE: hdl/srtl_chk.sv
// port level checker for the sorted range table lookup unit, bound to the top level
// depends on srtl_pkg and sorted_range_table_lookup_unit_assert.svh
`include "sorted_range_table_lookup_unit_assert.svh"

module srtl_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [srtl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [srtl_pkg::ST_W-1:0]       m_axis_tuser
);
  import srtl_pkg::*;

  // a stalled result keeps its contents
  `SRTL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // one request in flight at a time
  `SRTL_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

  // a failed append never reports a hit
  `SRTL_ASSERT(a_status_no_hit, m_axis_tvalid && m_axis_tuser != ST_OK |-> !m_axis_tdata[0], "hit on failed append")

  // no hit means no tag
  `SRTL_ASSERT(a_miss_no_tag, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[TAG_W:1] == '0, "tag without hit")

  // reset drops any pending result
  `SRTL_ASSERT_RST(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind sorted_range_table_lookup_unit srtl_chk u_srtl_chk (.*);
